@@ hdl/mpnc_pkg.sv @@
// Shared constants, coefficient table and helper types for the notch cascade.
`timescale 1ns / 1ps

package mpnc_pkg;

  // Field and storage widths fixed by the data format.
  localparam int CHAN_BITS    = 6;
  localparam int DELAY_BITS   = 48;
  localparam int SEC_COUNT    = 3;
  localparam int WORDS_PER_CH = 2 * SEC_COUNT;
  localparam int COEF_BITS    = 32;
  localparam int TERM_BITS    = 50;
  localparam int ACC_BITS     = 52;

  // Signed Q2.30 coefficients of one biquad notch section.
  typedef struct packed {
    logic signed [COEF_BITS-1:0] gain;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } notch_coef_t;

  // Two 50 Hz notches with different pole radii, then a 100 Hz notch.
  function automatic notch_coef_t notch_coef(input logic [1:0] sec);
    notch_coef_t c;
    case (sec)
      2'd1: begin
        c.gain = 32'sd1064243063;
        c.b1   = -32'sd2042539587;
        c.a1   = -32'sd2030724990;
        c.a2   = 32'sd1055341604;
      end
      2'd2: begin
        c.gain = 32'sd1060415548;
        c.b1   = -32'sd1737487951;
        c.a1   = -32'sd1715923881;
        c.a2   = 32'sd1047089271;
      end
      default: begin
        c.gain = 32'sd1064243063;
        c.b1   = -32'sd2042539587;
        c.a1   = -32'sd2018058849;
        c.a2   = 32'sd1054315337;
      end
    endcase
    return c;
  endfunction

endpackage

@@ hdl/multichannel_powerline_notch_cascade_unit.sv @@
// Top level of the three-section power-line notch cascade.
// The engine takes one sample at a time, its pace set by the single shared 33 x 32
// multiplier (21 products per sample) and the delay memory, with one read port and
// one write port (6 reads, 6 writes). Up to five samples may be in flight in
// the input register, queue, engine and output register. Reset clears per-channel
// history flags at once, so all delays read as zero.
`timescale 1ns / 1ps

module multichannel_powerline_notch_cascade_unit #(
  parameter int CHANNELS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: channel, sample, zero fill.
  input  logic [((mpnc_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0: channel_out, filtered_sample, zero fill.
  output logic [((mpnc_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int CB  = mpnc_pkg::CHAN_BITS;
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW  = $clog2(CHANNELS * mpnc_pkg::WORDS_PER_CH);
  localparam int IW  = CB + CW + AW + SAMPLE_BITS;
  localparam int ODW = ((CB + SAMPLE_BITS + 7) / 8) * 8;

  logic                   f_valid;
  logic                   f_ready;
  logic [IW-1:0]          f_item;
  logic                   q_valid;
  logic                   q_ready;
  logic [IW-1:0]          q_item;
  logic [CB-1:0]          res_ch;
  logic [SAMPLE_BITS-1:0] res_x;

  // Input register and channel mapping.
  mpnc_front #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_channel_i(s_axis_tdata[CB-1:0]),
    .in_sample_i (s_axis_tdata[CB +: SAMPLE_BITS]),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready),
    .item_o      (f_item)
  );

  // Decoupling queue.
  mpnc_queue #(
    .WIDTH(IW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (f_item),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_item)
  );

  // Filter engine with its output register.
  mpnc_back #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_channel_o(res_ch),
    .res_sample_o (res_x)
  );

  assign m_axis_tdata = ODW'({res_x, res_ch});

endmodule

@@ hdl/mpnc_front.sv @@
// Input stage: takes samples, maps the channel to its history row and base address.
`timescale 1ns / 1ps

module mpnc_front #(
  parameter int CHANNELS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mpnc_pkg::CHAN_BITS-1:0]      in_channel_i,
  input  logic [SAMPLE_BITS-1:0]              in_sample_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output logic [mpnc_pkg::CHAN_BITS + ((CHANNELS > 1) ? $clog2(CHANNELS) : 1)
                + $clog2(CHANNELS * mpnc_pkg::WORDS_PER_CH) + SAMPLE_BITS - 1:0] item_o
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = $clog2(CHANNELS * mpnc_pkg::WORDS_PER_CH);
  localparam int NCH   = 1 << mpnc_pkg::CHAN_BITS;

  logic                           valid_q;
  logic [mpnc_pkg::CHAN_BITS-1:0] channel_q;
  logic [CW-1:0]                  index_q;
  logic [AW-1:0]                  base_q;
  logic [SAMPLE_BITS-1:0]         sample_q;
  logic [CW-1:0]                  idx_tab [NCH];
  logic [CW-1:0]                  index_d;

  // Channel number folded onto the number of histories kept.
  for (genvar g = 0; g < NCH; g++) begin : g_idx
    assign idx_tab[g] = CW'(g % CHANNELS);
  end

  assign index_d    = idx_tab[in_channel_i];
  assign in_ready_o = !valid_q || item_ready_i;

  // Holding register; it refills in the cycle it hands its transaction on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      channel_q <= in_channel_i;
      index_q   <= index_d;
      base_q    <= AW'(AW'(index_d) * AW'(mpnc_pkg::WORDS_PER_CH));
      sample_q  <= in_sample_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = {sample_q, base_q, index_q, channel_q};

endmodule

@@ hdl/mpnc_queue.sv @@
// Two-entry queue between the input stage and the filter engine.
`timescale 1ns / 1ps

module mpnc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/mpnc_back.sv @@
// Filter engine: per-channel delay memory, shared multiplier and section sequencer.
`timescale 1ns / 1ps

module mpnc_back #(
  parameter int CHANNELS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  logic [mpnc_pkg::CHAN_BITS + ((CHANNELS > 1) ? $clog2(CHANNELS) : 1)
                + $clog2(CHANNELS * mpnc_pkg::WORDS_PER_CH) + SAMPLE_BITS - 1:0] item_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [mpnc_pkg::CHAN_BITS-1:0]      res_channel_o,
  output logic [SAMPLE_BITS-1:0]              res_sample_o
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * mpnc_pkg::WORDS_PER_CH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CB    = mpnc_pkg::CHAN_BITS;
  localparam int DB    = mpnc_pkg::DELAY_BITS;
  localparam int TB    = mpnc_pkg::TERM_BITS;
  localparam int AB    = mpnc_pkg::ACC_BITS;
  localparam int SB    = SAMPLE_BITS;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_ISSUE = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_FIN1  = 7'b0010000,
    ST_FIN2  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    OPK_NONE = 2'd0,
    OPK_GAIN = 2'd1,
    OPK_HI   = 2'd2,
    OPK_LO   = 2'd3
  } op_kind_e;

  // Tag that travels with each product down the datapath.
  typedef struct packed {
    op_kind_e kind;
    logic     to_b;
    logic     neg;
  } tag_t;

  state_e                  state_q;
  logic [2:0]              cnt_q;
  logic [1:0]              sec_q;
  logic [CB-1:0]           ch_q;
  logic [CW-1:0]           idx_q;
  logic [AW-1:0]           base_q;
  logic signed [SB-1:0]    x_q;
  logic signed [DB-1:0]    zs_q [mpnc_pkg::WORDS_PER_CH];
  logic                    chv_q [CHANNELS];

  logic [DB-1:0]           mem [DEPTH];
  logic [DB-1:0]           rd_q;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [DB-1:0]           wd;

  logic signed [32:0]      a_op;
  logic signed [31:0]      b_op;
  logic signed [64:0]      prod_d;
  logic signed [64:0]      prod_q;
  tag_t                    tag_d;
  tag_t                    m_tag_q;
  logic signed [55:0]      hi_q;
  logic signed [79:0]      full;
  logic signed [TB-1:0]    term_d;
  logic signed [TB-1:0]    term_q;
  tag_t                    c_tag_q;
  logic signed [AB-1:0]    accw_q;
  logic signed [AB-1:0]    accb_q;
  logic signed [AB-1:0]    term_ext;
  logic signed [DB-1:0]    wc_d;
  logic signed [DB-1:0]    wc_q;
  logic signed [AB-1:0]    y_d;
  logic signed [AB-1:0]    y_adj;
  logic signed [35:0]      yi;
  logic [SB-1:0]           sat_d;
  logic                    res_valid_q;
  logic [CB-1:0]           res_ch_q;
  logic [SB-1:0]           res_x_q;
  logic                    res_load;
  logic signed [DB-1:0]    z1;
  logic signed [DB-1:0]    z2;
  mpnc_pkg::notch_coef_t   cf;

  assign item_ready_o = (state_q == ST_IDLE);
  assign res_load     = (state_q == ST_DONE) && (!res_valid_q || res_ready_i);
  assign z1           = zs_q[0];
  assign z2           = zs_q[1];
  assign cf           = mpnc_pkg::notch_coef(sec_q);

  // Operand selection: z products are split into a signed high and an unsigned low half.
  always_comb begin
    a_op  = '0;
    b_op  = '0;
    tag_d = '{kind: OPK_NONE, to_b: 1'b0, neg: 1'b0};
    if (state_q == ST_ISSUE) begin
      case (cnt_q)
        3'd0: begin
          a_op  = {{(33-SB){x_q[SB-1]}}, x_q};
          b_op  = cf.gain;
          tag_d = '{kind: OPK_GAIN, to_b: 1'b0, neg: 1'b0};
        end
        3'd1: begin
          a_op  = {{9{z1[DB-1]}}, z1[DB-1:24]};
          b_op  = cf.a1;
          tag_d = '{kind: OPK_HI, to_b: 1'b0, neg: 1'b1};
        end
        3'd2: begin
          a_op  = {9'd0, z1[23:0]};
          b_op  = cf.a1;
          tag_d = '{kind: OPK_LO, to_b: 1'b0, neg: 1'b1};
        end
        3'd3: begin
          a_op  = {{9{z2[DB-1]}}, z2[DB-1:24]};
          b_op  = cf.a2;
          tag_d = '{kind: OPK_HI, to_b: 1'b0, neg: 1'b1};
        end
        3'd4: begin
          a_op  = {9'd0, z2[23:0]};
          b_op  = cf.a2;
          tag_d = '{kind: OPK_LO, to_b: 1'b0, neg: 1'b1};
        end
        3'd5: begin
          a_op  = {{9{z1[DB-1]}}, z1[DB-1:24]};
          b_op  = cf.b1;
          tag_d = '{kind: OPK_HI, to_b: 1'b1, neg: 1'b0};
        end
        3'd6: begin
          a_op  = {9'd0, z1[23:0]};
          b_op  = cf.b1;
          tag_d = '{kind: OPK_LO, to_b: 1'b1, neg: 1'b0};
        end
        default: begin
          a_op  = '0;
          b_op  = '0;
          tag_d = '{kind: OPK_NONE, to_b: 1'b0, neg: 1'b0};
        end
      endcase
    end
  end

  assign prod_d = 65'(a_op) * 65'(b_op);

  // Combine stage: glue the two halves and floor to Q16. The low-half product is
  // negative whenever the coefficient is, so it is sign extended.
  assign full = (80'(hi_q) <<< 24) + 80'($signed(prod_q[56:0]));

  always_comb begin
    case (m_tag_q.kind)
      OPK_GAIN: term_d = prod_q[63:14];
      OPK_LO:   term_d = full[79:30];
      default:  term_d = '0;
    endcase
  end

  assign term_ext = AB'(term_q);

  // Section finish: clamp the new delay, add the feed-forward part, truncate and saturate.
  always_comb begin
    if (accw_q[AB-1:DB-1] == {(AB-DB+1){accw_q[AB-1]}}) begin
      wc_d = accw_q[DB-1:0];
    end else if (accw_q[AB-1]) begin
      wc_d = {1'b1, {(DB-1){1'b0}}};
    end else begin
      wc_d = {1'b0, {(DB-1){1'b1}}};
    end
  end

  assign y_d   = AB'(wc_q) + accb_q;
  assign y_adj = y_d[AB-1] ? (y_d + AB'(65535)) : y_d;
  assign yi    = y_adj[AB-1:16];

  always_comb begin
    if (yi[35:SB-1] == {(37-SB){yi[35]}}) begin
      sat_d = yi[SB-1:0];
    end else if (yi[35]) begin
      sat_d = {1'b1, {(SB-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // Delay memory ports.
  assign rd_en   = (state_q == ST_LOAD) && (cnt_q < 3'd6);
  assign rd_addr = base_q + AW'(cnt_q);
  assign we      = (state_q == ST_FIN1) || (state_q == ST_FIN2);
  assign wa      = base_q + AW'({sec_q, (state_q == ST_FIN1)});
  assign wd      = (state_q == ST_FIN1) ? z1 : wc_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Sequencer and history flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
      sec_q   <= 2'd0;
      for (int i = 0; i < CHANNELS; i++) begin
        chv_q[i] <= 1'b0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            cnt_q   <= 3'd0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (cnt_q == 3'd6) begin
            cnt_q   <= 3'd0;
            sec_q   <= 2'd0;
            state_q <= ST_ISSUE;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_ISSUE: begin
          if (cnt_q == 3'd6) begin
            cnt_q   <= 3'd0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (cnt_q == 3'd1) begin
            state_q <= ST_FIN1;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_FIN1: begin
          state_q <= ST_FIN2;
        end
        ST_FIN2: begin
          cnt_q <= 3'd0;
          if (sec_q == 2'd2) begin
            chv_q[idx_q] <= 1'b1;
            state_q      <= ST_DONE;
          end else begin
            sec_q   <= sec_q + 2'd1;
            state_q <= ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Pipeline tags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tag_q <= '{kind: OPK_NONE, to_b: 1'b0, neg: 1'b0};
      c_tag_q <= '{kind: OPK_NONE, to_b: 1'b0, neg: 1'b0};
    end else begin
      m_tag_q <= tag_d;
      c_tag_q <= m_tag_q;
      if (m_tag_q.kind == OPK_HI) begin
        c_tag_q.kind <= OPK_NONE;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    term_q <= term_d;
    if (m_tag_q.kind == OPK_HI) begin
      hi_q <= prod_q[55:0];
    end

    // Accumulate, or start a fresh section.
    if ((state_q == ST_LOAD) && (cnt_q == 3'd6)) begin
      accw_q <= '0;
      accb_q <= AB'(zs_q[2]);
    end else if (state_q == ST_FIN2) begin
      accw_q <= '0;
      accb_q <= AB'(zs_q[3]);
    end else if (c_tag_q.kind != OPK_NONE) begin
      if (c_tag_q.to_b) begin
        accb_q <= accb_q + term_ext;
      end else if (c_tag_q.neg) begin
        accw_q <= accw_q - term_ext;
      end else begin
        accw_q <= accw_q + term_ext;
      end
    end

    if (state_q == ST_IDLE && item_valid_i) begin
      ch_q   <= item_i[CB-1:0];
      idx_q  <= item_i[CB +: CW];
      base_q <= item_i[CB+CW +: AW];
      x_q    <= item_i[CB+CW+AW +: SB];
    end

    // History words arrive one per cycle; a channel never written reads as zero.
    if ((state_q == ST_LOAD) && (cnt_q != 3'd0)) begin
      for (int i = 0; i < mpnc_pkg::WORDS_PER_CH - 1; i++) begin
        zs_q[i] <= zs_q[i+1];
      end
      zs_q[mpnc_pkg::WORDS_PER_CH-1] <= chv_q[idx_q] ? rd_q : '0;
    end else if (state_q == ST_FIN2) begin
      for (int i = 0; i < mpnc_pkg::WORDS_PER_CH - 2; i++) begin
        zs_q[i] <= zs_q[i+2];
      end
    end

    if (state_q == ST_FIN1) begin
      wc_q <= wc_d;
    end
    if (state_q == ST_FIN2) begin
      x_q <= sat_d;
    end

    if (res_load) begin
      res_ch_q <= ch_q;
      res_x_q  <= x_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign res_channel_o = res_ch_q;
  assign res_sample_o  = res_x_q;

endmodule

@@ hdl/mpnc_checker.sv @@
// Port-level checks for the notch cascade and their binding to the top level.
`timescale 1ns / 1ps

module mpnc_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((mpnc_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam logic [3:0] MAX_IN_FLIGHT = 4'd5;

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Samples taken in whose results have not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  // A stalled result holds its value.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // Every result belongs to a sample taken in earlier.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 4'd0))
    else $error("result transaction without a pending sample");

  // Input stage, queue, engine and output register bound the samples in flight.
  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_IN_FLIGHT)
    else $error("more samples in flight than the design can hold");

  // A sample entering an empty block cannot produce a result in the next cycle.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (pend_q == 4'd0)) |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind multichannel_powerline_notch_cascade_unit mpnc_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mpnc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
